// ===== hw/rtl/skgc_pkg.sv =====
// ---------------------------------------------------------------------------
// Soft-knee gain computer package
// Widths, fixed-point constants, register indexes and the divider word type
// shared by the gain computer and its division steps.
// ---------------------------------------------------------------------------
package skgc_pkg;

    // Fraction bits of every level, knee, ratio and gain value.
    localparam int FRAC_BITS = 8;

    localparam int LVL_W     = 17;   // detector level and threshold
    localparam int RATIO_W   = 15;   // ratio register
    localparam int KNEE_W    = 14;   // knee width register
    localparam int GAIN_W    = 18;   // gain change result
    localparam int CFG_IDX_W = 2;    // configuration register index
    localparam int CFG_W     = 17;   // configuration write data

    // Clamped ratio, wide enough to hold 1.0 for FRAC_BITS up to 16.
    localparam int R_W       = 17;
    localparam int RNUM_W    = RATIO_W;          // ratio minus 1.0
    localparam int D2_W      = LVL_W + 4;        // doubled distance, signed
    localparam int P2_W      = KNEE_W + 1;       // position inside the knee
    localparam int BASE_W    = 2 * P2_W;         // squared position or distance
    localparam int KR_W      = KNEE_W + R_W;     // knee times ratio
    localparam int N_W       = RNUM_W + BASE_W;  // numerator
    localparam int DEN_W     = KR_W + 3;         // denominator
    localparam int A_W       = N_W + 2;          // rounded dividend
    localparam int B_W       = DEN_W + 1;        // rounded divisor
    localparam int Q_W       = 17;               // quotient bits kept
    localparam int BS_W      = B_W + Q_W - 1;    // divisor aligned to the top bit

    localparam logic [R_W-1:0] RATIO_ONE  = {{(R_W-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [Q_W-1:0] GAIN_LIMIT = Q_W'(98304);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_RATIO     = 2'd1,
        CFG_KNEE      = 2'd2,
        CFG_UPWARD    = 2'd3
    } t_cfg_index;

    // One word in flight through the restoring divider.
    typedef struct packed {
        logic [A_W-1:0]  rem;   // partial remainder
        logic [BS_W-1:0] dvs;   // divisor, shifted down one place per step
        logic [Q_W-1:0]  quo;   // quotient bits so far
        logic            sat;   // quotient does not fit, result saturates
        logic            up;    // upward mode for this word
    } t_div_word;

endpackage

// ===== hw/rtl/skgc_div_step.sv =====
// ---------------------------------------------------------------------------
// Soft-knee gain computer division step
// One registered restoring division step: develops one quotient bit.
// ---------------------------------------------------------------------------
module skgc_div_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic                 i_valid,
    input  skgc_pkg::t_div_word  i_word,
    output logic                 o_valid,
    output skgc_pkg::t_div_word  o_word
);
    import skgc_pkg::*;

    logic      n_fit;
    t_div_word n_word;
    logic      r_valid;
    t_div_word r_word;

    // When the divisor fits it is not above the remainder, so its low bits suffice.
    always_comb begin
        n_fit      = {{(BS_W-A_W){1'b0}}, i_word.rem} >= i_word.dvs;
        n_word     = i_word;
        if (n_fit) begin
            n_word.rem = i_word.rem - i_word.dvs[A_W-1:0];
        end
        n_word.quo = {i_word.quo[Q_W-2:0], n_fit};
        n_word.dvs = i_word.dvs >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
        if (i_load) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== hw/rtl/soft_knee_gain_computer.sv =====
// ---------------------------------------------------------------------------
// Soft-knee gain computer
// Maps a detector level in dB to the gain change of a soft-knee compressor
// or expander curve, one word per clock while the receiver takes the output.
// ---------------------------------------------------------------------------
// Usage:
// Detector levels arrive on the input channel (i_in_valid / o_in_ready) as
// signed values in 1/256 dB; gain changes leave on the output channel
// (o_out_valid / i_out_ready), saturated to +/-384 dB. Threshold, ratio,
// knee width and mode are written through the configuration channel, which
// is always ready; write it only while no word is in flight.
// The pipeline has 23 register stages: five front stages (distance, knee
// region, square, product, rounding setup), seventeen restoring division
// steps that each yield one quotient bit, and the output register. A word
// accepted at the input passes through these stages in that order and is
// presented by the output register. One word per cycle is sustained while
// the receiver is ready.
// Every stage has its own valid bit and loads whenever it is empty or the
// stage after it loads, so a stalled receiver only holds the words that
// cannot move, bubbles are squeezed out, and nothing is lost or repeated.
// Reset empties the pipeline and restores threshold 0 dB, ratio 1.0, hard
// knee and downward mode.
// ---------------------------------------------------------------------------
module soft_knee_gain_computer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [skgc_pkg::LVL_W-1:0]   i_detector_level,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [skgc_pkg::GAIN_W-1:0]  o_gain_change,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [skgc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [skgc_pkg::CFG_W-1:0]          i_cfg_data
);
    import skgc_pkg::*;

    localparam int FRONT = 5;
    localparam int NST   = FRONT + Q_W + 1;
    localparam logic signed [GAIN_W-1:0] GAIN_MAX = GAIN_W'(GAIN_LIMIT);

    // Configuration registers.
    logic signed [LVL_W-1:0] r_threshold;
    logic [RATIO_W-1:0]      r_ratio;
    logic [KNEE_W-1:0]       r_knee;
    logic                    r_upward;

    // Pipeline flow control: one valid bit and one load enable per stage.
    logic [NST-1:0] w_valid;
    logic [NST-1:0] w_load;

    // Derived configuration values.
    logic [R_W-1:0]           w_ratio_clamped;
    logic [RNUM_W-1:0]        w_ratio_num;
    logic signed [D2_W-1:0]   w_knee_s;

    // Stage 1: doubled distance above the threshold (less the knee in upward mode) and knee times ratio.
    logic                     r1_valid;
    logic signed [D2_W-1:0]   r1_d2;
    logic [KR_W-1:0]          r1_kr;
    logic                     r1_up;
    logic signed [D2_W-1:0]   n1_d2;

    // Stage 2: region decision.
    logic                     r2_valid;
    logic                     r2_knee;
    logic                     r2_hard;
    logic [P2_W-1:0]          r2_p2;
    logic [D2_W-2:0]          r2_dpos;
    logic [KR_W-1:0]          r2_kr;
    logic                     r2_up;
    logic signed [D2_W-1:0]   n2_p2;

    // Stage 3: squared knee position, plain distance or zero.
    logic                     r3_valid;
    logic [BASE_W-1:0]        r3_base;
    logic                     r3_knee;
    logic [KR_W-1:0]          r3_kr;
    logic                     r3_up;
    logic [BASE_W-1:0]        n3_base;

    // Stage 4: numerator and denominator.
    logic                     r4_valid;
    logic [N_W-1:0]           r4_num;
    logic [DEN_W-1:0]         r4_den;
    logic                     r4_up;

    // Stage 5: rounded dividend, aligned divisor and saturation check.
    logic                     r5_valid;
    t_div_word                r5_word;
    t_div_word                n5_word;
    logic [A_W-1:0]           n5_dividend;
    logic [B_W-1:0]           n5_divisor;

    // Division chain.
    t_div_word                w_div_word [0:Q_W];
    logic [Q_W:0]             w_div_valid;

    // Output register.
    logic                     r_out_valid;
    logic signed [GAIN_W-1:0] r_out_gain;
    logic                     r_out_up;
    logic [Q_W-1:0]           n_out_mag;
    logic signed [GAIN_W-1:0] n_out_gain;

    // -----------------------------------------------------------------------
    // Configuration port. Writes are taken at once; an index that is not a
    // register changes nothing.
    // -----------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_ratio     <= RATIO_ONE[RATIO_W-1:0];
            r_knee      <= '0;
            r_upward    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_THRESHOLD: begin
                    r_threshold <= $signed(i_cfg_data[LVL_W-1:0]);
                end
                CFG_RATIO: begin
                    r_ratio <= i_cfg_data[RATIO_W-1:0];
                end
                CFG_KNEE: begin
                    r_knee <= i_cfg_data[KNEE_W-1:0];
                end
                CFG_UPWARD: begin
                    r_upward <= i_cfg_data[0];
                end
                default: begin
                    r_upward <= r_upward;
                end
            endcase
        end
    end

    // A ratio below 1.0 acts as exactly 1.0, which makes the slope zero.
    assign w_ratio_clamped = ({{(R_W-RATIO_W){1'b0}}, r_ratio} < RATIO_ONE) ?
                             RATIO_ONE : {{(R_W-RATIO_W){1'b0}}, r_ratio};
    assign w_ratio_num     = RNUM_W'(w_ratio_clamped - RATIO_ONE);
    assign w_knee_s        = D2_W'(r_knee);

    // -----------------------------------------------------------------------
    // Flow control. A stage loads when it is empty or its successor loads.
    // -----------------------------------------------------------------------
    assign w_valid[0] = r1_valid;
    assign w_valid[1] = r2_valid;
    assign w_valid[2] = r3_valid;
    assign w_valid[3] = r4_valid;
    assign w_valid[4] = r5_valid;
    assign w_valid[NST-1] = r_out_valid;

    assign w_load[NST-1] = !w_valid[NST-1] || i_out_ready;

    genvar g_s;
    generate
        for (g_s = 0; g_s < NST - 1; g_s++) begin : g_load
            assign w_load[g_s] = !w_valid[g_s] || w_load[g_s+1];
        end
    endgenerate

    assign o_in_ready = w_load[0];

    // -----------------------------------------------------------------------
    // Front stages.
    // -----------------------------------------------------------------------
    // Working on doubled distances keeps the half-knee shift exact.
    assign n1_d2 = (D2_W'(i_detector_level) <<< 1) - (D2_W'(r_threshold) <<< 1)
                   - (r_upward ? w_knee_s : '0);

    // Only meaningful inside the knee, where it lies in 1 .. 2*knee - 1.
    assign n2_p2 = r1_d2 + w_knee_s;

    always_comb begin
        if (r2_knee) begin
            n3_base = BASE_W'(r2_p2) * BASE_W'(r2_p2);
        end else if (r2_hard) begin
            n3_base = BASE_W'(r2_dpos);
        end else begin
            n3_base = '0;
        end
    end

    // Round to nearest, ties up: (2*num + den) / (2*den).
    assign n5_dividend = {r4_num, 1'b0} + A_W'(r4_den);
    assign n5_divisor  = {r4_den, 1'b0};

    always_comb begin
        n5_word.rem = n5_dividend;
        n5_word.dvs = BS_W'(n5_divisor) << (Q_W - 1);
        n5_word.quo = '0;
        n5_word.sat = {{(B_W+Q_W-A_W){1'b0}}, n5_dividend} >=
                      ({{Q_W{1'b0}}, n5_divisor} << Q_W);
        n5_word.up  = r4_up;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            if (w_load[0]) begin
                r1_valid <= i_in_valid;
            end
            if (w_load[1]) begin
                r2_valid <= r1_valid;
            end
            if (w_load[2]) begin
                r3_valid <= r2_valid;
            end
            if (w_load[3]) begin
                r4_valid <= r3_valid;
            end
            if (w_load[4]) begin
                r5_valid <= r4_valid;
            end
        end

        if (w_load[0]) begin
            r1_d2 <= n1_d2;
            r1_kr <= KR_W'(r_knee) * KR_W'(w_ratio_clamped);
            r1_up <= r_upward;
        end
        if (w_load[1]) begin
            r2_knee <= (r_knee != '0) && (r1_d2 > -w_knee_s) && (r1_d2 < w_knee_s);
            r2_hard <= r1_d2 > 0;
            r2_p2   <= n2_p2[P2_W-1:0];
            r2_dpos <= r1_d2[D2_W-2:0];
            r2_kr   <= r1_kr;
            r2_up   <= r1_up;
        end
        if (w_load[2]) begin
            r3_base <= n3_base;
            r3_knee <= r2_knee;
            r3_kr   <= r2_kr;
            r3_up   <= r2_up;
        end
        if (w_load[3]) begin
            r4_num <= N_W'(w_ratio_num) * N_W'(r3_base);
            r4_den <= r3_knee ? {r3_kr, 3'b000} : DEN_W'({w_ratio_clamped, 1'b0});
            r4_up  <= r3_up;
        end
        if (w_load[4]) begin
            r5_word <= n5_word;
        end
    end

    // -----------------------------------------------------------------------
    // Restoring divider: one quotient bit per stage, most significant first.
    // -----------------------------------------------------------------------
    assign w_div_word[0]  = r5_word;
    assign w_div_valid[0] = r5_valid;

    genvar g_d;
    generate
        for (g_d = 0; g_d < Q_W; g_d++) begin : g_div
            skgc_div_step u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_load  (w_load[FRONT+g_d]),
                .i_valid (w_div_valid[g_d]),
                .i_word  (w_div_word[g_d]),
                .o_valid (w_div_valid[g_d+1]),
                .o_word  (w_div_word[g_d+1])
            );
            assign w_valid[FRONT+g_d] = w_div_valid[g_d+1];
        end
    endgenerate

    // -----------------------------------------------------------------------
    // Output register: saturate the magnitude, then apply the mode's sign.
    // -----------------------------------------------------------------------
    assign n_out_mag  = (w_div_word[Q_W].sat || (w_div_word[Q_W].quo > GAIN_LIMIT)) ?
                        GAIN_LIMIT : w_div_word[Q_W].quo;
    assign n_out_gain = w_div_word[Q_W].up ? $signed(GAIN_W'(n_out_mag))
                                           : -$signed(GAIN_W'(n_out_mag));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load[NST-1]) begin
            r_out_valid <= w_div_valid[Q_W];
        end
        if (w_load[NST-1]) begin
            r_out_gain <= n_out_gain;
            r_out_up   <= w_div_word[Q_W].up;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_gain_change = r_out_gain;

    // -----------------------------------------------------------------------
    // Assertions.
    // -----------------------------------------------------------------------
    // An upward-mode word never reports a reduction.
    a_upward_not_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_out_up) |-> !o_gain_change[GAIN_W-1])
        else $error("upward mode word carries a negative gain change");

    // The saturation logic keeps every result inside the gain limit.
    a_gain_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_gain_change <= GAIN_MAX) && (o_gain_change >= -GAIN_MAX)))
        else $error("gain change outside the saturation limit");

    // Reset empties every stage, so the block comes up ready and silent.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("pipeline not empty after reset");

endmodule
